FILE: sv/tq_pkg.sv
// ----------------------------------------------------------------------------
// Task queue package
// Shared sizes, operation and status codes and the control words between the
// queue top level and its cells.
// ----------------------------------------------------------------------------
package tq_pkg;

  localparam int DEPTH   = 16;
  localparam int ID_W    = 16;
  localparam int PRIO_W  = 8;
  localparam int CNT_W   = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_EXEC  = 2'd1,
    MODE_DEL   = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // broadcast to every cell for the word being accepted
  typedef struct packed {
    logic              shift_all;
    logic              del;
    logic              add;
    logic [ID_W-1:0]   new_id;
    logic [PRIO_W-1:0] new_prio;
    logic [ID_W-1:0]   target;
  } tq_ctrl_t;

  // where a cell stands relative to the fill count
  typedef struct packed {
    logic occ;
    logic tail;
  } tq_pos_t;

endpackage

FILE: sv/fifo_task_queue_delete_by_id_unit.sv
// ----------------------------------------------------------------------------
// FIFO task queue with delete by id
// Collapsing queue of tq_pkg::DEPTH cells; add, pop head, delete by id, clear.
// ----------------------------------------------------------------------------
// The done strobe and the result are registered at the accepting edge.
// Throughput: one word per cycle; busy stays low, as every operation finishes
// in the single compare-and-shift pass over the cell row.
// Reset: rst (synchronous) empties the queue and sets the next id to 1; the
// cell contents are not cleared and are only read below the fill count.
// The receiver cannot stall: each result is shown for exactly one cycle.
module fifo_task_queue_delete_by_id_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                mode,
  input  logic [tq_pkg::PRIO_W-1:0] priority_req,
  input  logic [tq_pkg::ID_W-1:0]   target_id,
  output logic                      done,
  output logic [1:0]                status,
  output logic [tq_pkg::ID_W-1:0]   task_id,
  output logic [tq_pkg::PRIO_W-1:0] task_priority,
  output logic [tq_pkg::CNT_W-1:0]  occupancy
);

  localparam int D = tq_pkg::DEPTH;

  logic                      accept;
  tq_pkg::mode_t             op;
  tq_pkg::tq_ctrl_t          ctrl;

  logic [tq_pkg::CNT_W-1:0]  count;
  logic [tq_pkg::CNT_W-1:0]  count_next;
  logic [tq_pkg::ID_W-1:0]   id_ctr;
  logic [tq_pkg::ID_W-1:0]   id_ctr_next;

  tq_pkg::tq_pos_t           pos   [D];
  logic                      found [D+1];
  logic                      first [D];
  logic [tq_pkg::ID_W-1:0]   c_id  [D];
  logic [tq_pkg::PRIO_W-1:0] c_pr  [D];
  logic [tq_pkg::ID_W-1:0]   n_id  [D];
  logic [tq_pkg::PRIO_W-1:0] n_pr  [D];

  logic [tq_pkg::ID_W-1:0]   hit_id;
  logic [tq_pkg::PRIO_W-1:0] hit_pr;

  tq_pkg::status_t           res_status;
  logic [tq_pkg::ID_W-1:0]   res_id;
  logic [tq_pkg::PRIO_W-1:0] res_pr;

  logic full;
  logic empty;

  // every operation completes in one pass, so the port never holds off
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign op     = tq_pkg::mode_t'(mode);
  assign full   = (count == tq_pkg::CNT_W'(D));
  assign empty  = (count == '0);

  // broadcast the accepted word to the cell row
  always_comb begin
    ctrl.shift_all = accept && (op == tq_pkg::MODE_EXEC) && !empty;
    ctrl.del       = accept && (op == tq_pkg::MODE_DEL);
    ctrl.add       = accept && (op == tq_pkg::MODE_ADD) && !full;
    ctrl.new_id    = id_ctr;
    ctrl.new_prio  = priority_req;
    ctrl.target    = target_id;
  end

  assign found[0] = 1'b0;

  // row of cells, head at index 0; each cell takes its right-hand neighbour
  for (genvar i = 0; i < D; i++) begin : g_cell
    assign pos[i].occ  = (tq_pkg::CNT_W'(i) < count);
    assign pos[i].tail = (tq_pkg::CNT_W'(i) == count);

    if (i == D - 1) begin : g_last
      // last cell drops out of range on a collapse; hold its own entry
      assign n_id[i] = c_id[i];
      assign n_pr[i] = c_pr[i];
    end else begin : g_mid
      assign n_id[i] = c_id[i+1];
      assign n_pr[i] = c_pr[i+1];
    end

    tq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .pos       (pos[i]),
      .found_in  (found[i]),
      .nbr_id    (n_id[i]),
      .nbr_prio  (n_pr[i]),
      .found_out (found[i+1]),
      .first_hit (first[i]),
      .id        (c_id[i]),
      .prio      (c_pr[i])
    );
  end

  // pick the entry of the one cell that holds the first match
  always_comb begin
    hit_id = '0;
    hit_pr = '0;
    for (int i = 0; i < D; i++) begin
      hit_id = hit_id | (first[i] ? c_id[i] : '0);
      hit_pr = hit_pr | (first[i] ? c_pr[i] : '0);
    end
  end

  // result and next fill count for the accepted word
  always_comb begin
    res_status  = tq_pkg::ST_OK;
    res_id      = '0;
    res_pr      = '0;
    count_next  = count;
    id_ctr_next = id_ctr;
    unique case (op)
      tq_pkg::MODE_ADD: begin
        if (full) begin
          res_status = tq_pkg::ST_FULL;
        end else begin
          res_id      = id_ctr;
          count_next  = count + 1'b1;
          id_ctr_next = id_ctr + 1'b1;
        end
      end
      tq_pkg::MODE_EXEC: begin
        if (empty) begin
          res_status = tq_pkg::ST_EMPTY;
        end else begin
          res_id     = c_id[0];
          res_pr     = c_pr[0];
          count_next = count - 1'b1;
        end
      end
      tq_pkg::MODE_DEL: begin
        if (found[D]) begin
          res_id     = hit_id;
          res_pr     = hit_pr;
          count_next = count - 1'b1;
        end else begin
          res_status = tq_pkg::ST_NOTFOUND;
        end
      end
      tq_pkg::MODE_CLEAR: begin
        count_next = '0;
      end
      default: begin
        res_status = tq_pkg::ST_OK;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      id_ctr <= tq_pkg::ID_W'(1);
      done   <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        count  <= count_next;
        id_ctr <= id_ctr_next;
      end
    end
  end

  // result register: hold the word for the strobe cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      status        <= res_status;
      task_id       <= res_id;
      task_priority <= res_pr;
      occupancy     <= count_next;
    end
  end

  // fill count never exceeds the row length
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= tq_pkg::CNT_W'(D))
    else $error("fill count beyond queue depth");

  // an add to a full queue reports full and leaves count and next id alone
  a_full_add: assert property (@(posedge clk) disable iff (rst)
    (accept && op == tq_pkg::MODE_ADD && full) |=>
      (status == tq_pkg::ST_FULL && count == $past(count) && id_ctr == $past(id_ctr)))
    else $error("add on full queue changed state");

  // a failed operation returns a zero id and priority
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != tq_pkg::ST_OK) |-> (task_id == '0 && task_priority == '0))
    else $error("non-ok result carries payload");

  // a successful delete shrinks the queue by exactly one entry
  a_del_shrink: assert property (@(posedge clk) disable iff (rst)
    (accept && op == tq_pkg::MODE_DEL && found[D]) |=>
      (count == $past(count) - 1'b1))
    else $error("delete did not remove one entry");

endmodule

FILE: sv/tq_cell.sv
// ----------------------------------------------------------------------------
// Task queue cell
// Holds one entry, compares it with the delete key, takes its neighbour's
// entry when the queue collapses over it and loads a new entry at the tail.
// ----------------------------------------------------------------------------
module tq_cell (
  input  logic                      clk,
  input  tq_pkg::tq_ctrl_t          ctrl,
  input  tq_pkg::tq_pos_t           pos,
  input  logic                      found_in,
  input  logic [tq_pkg::ID_W-1:0]   nbr_id,
  input  logic [tq_pkg::PRIO_W-1:0] nbr_prio,
  output logic                      found_out,
  output logic                      first_hit,
  output logic [tq_pkg::ID_W-1:0]   id,
  output logic [tq_pkg::PRIO_W-1:0] prio
);

  logic match;
  logic take_nbr;
  logic take_new;

  assign match     = ctrl.del && pos.occ && (id == ctrl.target);
  assign found_out = found_in || match;
  assign first_hit = match && !found_in;

  // collapse: on a pop every occupied cell advances, on a delete only the
  // occupied cells from the removed one onwards
  assign take_nbr = pos.occ && (ctrl.shift_all || (ctrl.del && found_out));
  assign take_new = ctrl.add && pos.tail;

  always_ff @(posedge clk) begin
    if (take_nbr) begin
      id   <= nbr_id;
      prio <= nbr_prio;
    end else if (take_new) begin
      id   <= ctrl.new_id;
      prio <= ctrl.new_prio;
    end
  end

endmodule

FILE: tb/tb_fifo_task_queue_delete_by_id_unit.sv
// ----------------------------------------------------------------------------
// Task queue with delete by id: self-checking testbench
// Sends add, pop, delete and clear words through the start/busy handshake and
// checks every done strobe against a local queue predictor, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_fifo_task_queue_delete_by_id_unit;

  // one predicted done strobe
  typedef struct packed {
    tq_pkg::status_t           st;
    logic [tq_pkg::ID_W-1:0]   id;
    logic [tq_pkg::PRIO_W-1:0] prio;
    logic [tq_pkg::CNT_W-1:0]  occ;
  } outcome_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        start = 1'b0;
  logic                        busy;
  logic [1:0]                  mode = tq_pkg::MODE_ADD;
  logic [tq_pkg::PRIO_W-1:0]   priority_req = '0;
  logic [tq_pkg::ID_W-1:0]     target_id = '0;
  logic                        done;
  logic [1:0]                  status;
  logic [tq_pkg::ID_W-1:0]     task_id;
  logic [tq_pkg::PRIO_W-1:0]   task_priority;
  logic [tq_pkg::CNT_W-1:0]    occupancy;

  // shadow queue: index 0 is the head
  logic [tq_pkg::ID_W-1:0]     shadow_id [tq_pkg::DEPTH];
  logic [tq_pkg::PRIO_W-1:0]   shadow_prio [tq_pkg::DEPTH];
  int                          shadow_len = 0;
  logic [tq_pkg::ID_W-1:0]     next_task_id = tq_pkg::ID_W'(1);

  outcome_t                    pending_results [$];
  int                          idle_pct = 0;
  int                          words_sent = 0;
  int                          results_checked = 0;
  int                          full_rejects = 0;
  int                          errors = 0;

  fifo_task_queue_delete_by_id_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .mode          (mode),
    .priority_req  (priority_req),
    .target_id     (target_id),
    .done          (done),
    .status        (status),
    .task_id       (task_id),
    .task_priority (task_priority),
    .occupancy     (occupancy)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Close the gap left at position pos, keeping the order of the rest.
  function automatic void collapse_at(int pos);
    for (int k = pos; k < shadow_len - 1; k++) begin
      shadow_id[k]   = shadow_id[k + 1];
      shadow_prio[k] = shadow_prio[k + 1];
    end
    shadow_len--;
  endfunction

  // Apply one word to the shadow queue and return the strobe it must give.
  function automatic outcome_t apply_word(tq_pkg::mode_t m,
                                          logic [tq_pkg::PRIO_W-1:0] pr,
                                          logic [tq_pkg::ID_W-1:0] tid);
    outcome_t r;
    int       hit;
    r    = '0;
    r.st = tq_pkg::ST_OK;
    hit  = -1;
    case (m)
      tq_pkg::MODE_ADD: begin
        if (shadow_len == tq_pkg::DEPTH) begin
          // full: nothing stored and no id used up
          r.st = tq_pkg::ST_FULL;
          full_rejects++;
        end else begin
          shadow_id[shadow_len]   = next_task_id;
          shadow_prio[shadow_len] = pr;
          shadow_len++;
          r.id = next_task_id;
          next_task_id++;
        end
      end
      tq_pkg::MODE_EXEC: begin
        if (shadow_len == 0) begin
          r.st = tq_pkg::ST_EMPTY;
        end else begin
          r.id   = shadow_id[0];
          r.prio = shadow_prio[0];
          collapse_at(0);
        end
      end
      tq_pkg::MODE_DEL: begin
        // the match nearest the head wins
        for (int k = 0; k < shadow_len; k++) begin
          if (shadow_id[k] == tid && hit < 0) hit = k;
        end
        if (hit < 0) begin
          r.st = tq_pkg::ST_NOTFOUND;
        end else begin
          r.id   = shadow_id[hit];
          r.prio = shadow_prio[hit];
          collapse_at(hit);
        end
      end
      default: begin
        shadow_len = 0;
      end
    endcase
    r.occ = tq_pkg::CNT_W'(shadow_len);
    return r;
  endfunction

  // Offer one word, hold it until accepted, then predict its strobe. Called
  // just after a rising edge; leaves just after the accepting edge.
  task automatic send_word(tq_pkg::mode_t m, logic [tq_pkg::PRIO_W-1:0] pr,
                           logic [tq_pkg::ID_W-1:0] tid);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start        <= 1'b1;
    mode         <= m;
    priority_req <= pr;
    target_id    <= tid;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(apply_word(m, pr, tid));
    words_sent++;
  endtask

  // Drop start and hold off until every predicted strobe has been seen.
  task automatic wait_for_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Check each done strobe against the oldest prediction.
  always @(posedge clk) begin
    outcome_t exp_r;
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("done strobe with no word outstanding");
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        results_checked++;
        if (status !== exp_r.st) begin
          $error("status: expected %0d, got %0d", exp_r.st, status);
          errors++;
        end
        if (task_id !== exp_r.id) begin
          $error("task_id: expected %0d, got %0d", exp_r.id, task_id);
          errors++;
        end
        if (task_priority !== exp_r.prio) begin
          $error("task_priority: expected %0d, got %0d", exp_r.prio, task_priority);
          errors++;
        end
        if (occupancy !== exp_r.occ) begin
          $error("occupancy: expected %0d, got %0d", exp_r.occ, occupancy);
          errors++;
        end
      end
    end
  end

  // Pop, delete and clear on an empty queue, with both extreme target ids.
  task automatic test_empty_queue();
    send_word(tq_pkg::MODE_EXEC, 8'h00, 16'h0000);
    send_word(tq_pkg::MODE_DEL, 8'hFF, 16'h0000);
    send_word(tq_pkg::MODE_DEL, 8'h00, 16'hFFFF);
    send_word(tq_pkg::MODE_CLEAR, 8'hFF, 16'hFFFF);
  endtask

  // Fill every cell, priorities running from 0 to 255, then add once more.
  task automatic test_fill_to_full();
    for (int i = 0; i < tq_pkg::DEPTH; i++)
      send_word(tq_pkg::MODE_ADD, tq_pkg::PRIO_W'(i * 17), 16'h0000);
    send_word(tq_pkg::MODE_ADD, 8'h5A, 16'h0000);
  endtask

  // Delete at the head, the tail and the middle, miss once, pop, clear.
  task automatic test_delete_positions();
    send_word(tq_pkg::MODE_DEL, 8'h00, shadow_id[0]);
    send_word(tq_pkg::MODE_DEL, 8'h00, shadow_id[shadow_len - 1]);
    send_word(tq_pkg::MODE_DEL, 8'h00, shadow_id[shadow_len / 2]);
    send_word(tq_pkg::MODE_DEL, 8'h00, 16'hFFFF);
    send_word(tq_pkg::MODE_EXEC, 8'h00, 16'h0000);
    send_word(tq_pkg::MODE_CLEAR, 8'h00, 16'h0000);
  endtask

  // Random traffic. Alternate between fill-leaning and drain-leaning phases
  // so the queue swings between empty and full; most deletes aim at an id
  // that is actually queued.
  task automatic test_random_traffic(int n_words);
    bit                      filling;
    int                      r;
    tq_pkg::mode_t           m;
    logic [tq_pkg::ID_W-1:0] tid;
    filling = 1'b1;
    for (int i = 0; i < n_words; i++) begin
      if (i % 60 == 0) filling = ~filling;
      // hold a long stretch at full rate, idle at random elsewhere
      idle_pct = (i >= n_words / 3 && i < n_words / 3 + 250) ? 0 : 36;
      // pause once until the block has answered everything
      if (i == n_words / 2) wait_for_results();
      r = $urandom_range(99);
      if (filling)
        m = (r < 55) ? tq_pkg::MODE_ADD : (r < 70) ? tq_pkg::MODE_EXEC :
            (r < 96) ? tq_pkg::MODE_DEL : tq_pkg::MODE_CLEAR;
      else
        m = (r < 25) ? tq_pkg::MODE_ADD : (r < 55) ? tq_pkg::MODE_EXEC :
            (r < 97) ? tq_pkg::MODE_DEL : tq_pkg::MODE_CLEAR;
      tid = tq_pkg::ID_W'($urandom);
      if (m == tq_pkg::MODE_DEL && shadow_len > 0 && $urandom_range(9) < 8)
        tid = shadow_id[$urandom_range(shadow_len - 1)];
      send_word(m, tq_pkg::PRIO_W'($urandom_range(255)), tid);
    end
  endtask

  initial begin
    int guard;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    idle_pct = 36;
    test_empty_queue();
    test_fill_to_full();
    test_delete_positions();
    test_random_traffic(850);

    // drain, then allow the registered results to settle
    start <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < 200) begin
      @(posedge clk);
      guard++;
    end
    repeat (3) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d predicted results never arrived", pending_results.size());
      errors++;
    end

    $display("Sent %0d words, checked %0d results; %0d adds refused on a full queue,",
             words_sent, results_checked, full_rejects);
    $display("with empty-queue misses, head/tail/middle deletes and mixed random traffic.");
    if (errors == 0)
      $display("tb_fifo_task_queue_delete_by_id_unit: done, clean");
    else
      $display("tb_fifo_task_queue_delete_by_id_unit: done, errors");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #40_000;
    $display("tb_fifo_task_queue_delete_by_id_unit: done, errors");
    $finish;
  end

endmodule

FILE: files.f
sv/tq_pkg.sv
sv/tq_cell.sv
sv/fifo_task_queue_delete_by_id_unit.sv
tb/tb_fifo_task_queue_delete_by_id_unit.sv
